// ===== design/smb_pkg.sv =====
package smb_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  // Fault codes
  localparam logic [3:0] F_NONE      = 4'd0;
  localparam logic [3:0] F_FETCH     = 4'd1;
  localparam logic [3:0] F_OPCODE    = 4'd2;
  localparam logic [3:0] F_OVERFLOW  = 4'd3;
  localparam logic [3:0] F_UNDERFLOW = 4'd4;
  localparam logic [3:0] F_INDEX     = 4'd5;
  localparam logic [3:0] F_ALLOC     = 4'd6;
  localparam logic [3:0] F_HEAP      = 4'd7;
  localparam logic [3:0] F_FULL      = 4'd8;

  // Opcodes
  localparam logic [31:0] OP_HALT = 32'd0;
  localparam logic [31:0] OP_PUSH = 32'd1;
  localparam logic [31:0] OP_COPY = 32'd2;
  localparam logic [31:0] OP_STORE = 32'd3;
  localparam logic [31:0] OP_DROP = 32'd4;
  localparam logic [31:0] OP_SWAP = 32'd5;
  localparam logic [31:0] OP_JUMP = 32'd6;
  localparam logic [31:0] OP_JIFZ = 32'd7;
  localparam logic [31:0] OP_NEW  = 32'd8;
  localparam logic [31:0] OP_SV32 = 32'd9;
  localparam logic [31:0] OP_RD32 = 32'd10;
  localparam logic [31:0] OP_GT   = 32'd11;
  localparam logic [31:0] OP_ADD  = 32'd12;
  localparam logic [31:0] OP_SUB  = 32'd13;

  localparam logic [23:0] STEP_LIMIT_RST = 24'd1048576;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLR   = 12'b000000000010,
    S_FETCH = 12'b000000000100,
    S_OP    = 12'b000000001000,
    S_ARG   = 12'b000000010000,
    S_STK   = 12'b000000100000,
    S_SWP   = 12'b000001000000,
    S_TOPRD = 12'b000010000000,
    S_TOPLD = 12'b000100000000,
    S_HWR   = 12'b001000000000,
    S_HRD   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

endpackage

// ===== design/smb_ram.sv =====
module smb_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== design/stack_machine_with_bump_heap_unit.sv =====
// Stack machine with bump heap. Program words, value stack and heap bytes each
// live in a single-port RAM with registered read. A load or kind-3 item goes
// straight to posting its result; a clear item sweeps the heap RAM to zero
// before posting, and the same sweep runs after reset before the first item
// is taken. A run item steps through its instructions at a pace set by the
// shared program and stack RAM ports (fetch, operand, stack read, top-of-stack
// reload), and rd32 and sv32 move one byte at a time over the byte-wide heap
// port. The next item is taken only after the result has been transferred.
module stack_machine_with_bump_heap_unit #(
  parameter int PROGRAM_DEPTH = 64,
  parameter int STACK_DEPTH   = 32,
  parameter int HEAP_BYTES    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_step_limit_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_kind_i,
  input  logic signed [31:0] in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_status_o,
  output logic [3:0]  out_fault_code_o,
  output logic signed [31:0] out_top_value_o,
  output logic [5:0]  out_stack_depth_o,
  output logic [5:0]  out_heap_used_o,
  output logic [6:0]  out_stop_pc_o
);

  localparam int PA  = $clog2(PROGRAM_DEPTH);
  localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int SA  = $clog2(STACK_DEPTH);
  localparam int SW  = $clog2(STACK_DEPTH + 1);
  localparam int HA  = $clog2(HEAP_BYTES);
  localparam int HW  = $clog2(HEAP_BYTES + 1);

  smb_pkg::state_e st_q, st_d;
  logic [23:0] limit_q, limit_d;
  logic [23:0] rem_q, rem_d;
  logic [PCW-1:0] len_q, len_d, pc_q, pc_d, at_q, at_d;
  logic [SW-1:0] dep_q, dep_d;
  logic [HW-1:0] hl_q, hl_d;
  logic [31:0] top_q, top_d, op_q, op_d, arg_q, arg_d, rd_q, rd_d;
  logic [31:0] ha_q, ha_d;
  logic [2:0] cnt_q, cnt_d;
  logic [HA-1:0] swp_q, swp_d;
  logic init_q, init_d;
  logic out_vld_q, out_vld_d;
  logic [1:0] ost_q, ost_d;
  logic [3:0] ofc_q, ofc_d;
  logic [PCW-1:0] opc_q, opc_d;

  logic p_we, s_we, h_we;
  logic [PA-1:0] p_addr;
  logic [SA-1:0] s_addr;
  logic [HA-1:0] h_addr;
  logic [31:0] p_wdata, p_rdata, s_wdata, s_rdata, res;
  logic [7:0] h_wdata, h_rdata;
  logic [32:0] d32;

  smb_ram #(.Width(32), .Depth(PROGRAM_DEPTH)) u_prog (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wdata), .rdata_o(p_rdata));
  smb_ram #(.Width(32), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata));
  smb_ram #(.Width(8), .Depth(HEAP_BYTES)) u_heap (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wdata), .rdata_o(h_rdata));

  function automatic logic [PCW-1:0] sat_pc(logic [31:0] t);
    return (t >= 32'(PROGRAM_DEPTH)) ? PCW'(PROGRAM_DEPTH) : PCW'(t);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == smb_pkg::S_IDLE) && !out_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_status_o = ost_q;
  assign out_fault_code_o = ofc_q;
  assign out_top_value_o = top_q;
  assign out_stack_depth_o = 6'(dep_q);
  assign out_heap_used_o = 6'(hl_q);
  assign out_stop_pc_o = 7'(opc_q);

  // Sequencer
  always_comb begin
    st_d = st_q; limit_d = limit_q; rem_d = rem_q; len_d = len_q; pc_d = pc_q;
    at_d = at_q; dep_d = dep_q; hl_d = hl_q; top_d = top_q; op_d = op_q;
    arg_d = arg_q; rd_d = rd_q; ha_d = ha_q; cnt_d = cnt_q; swp_d = swp_q;
    init_d = init_q;
    out_vld_d = out_vld_q; ost_d = ost_q; ofc_d = ofc_q; opc_d = opc_q;
    p_we = 1'b0; p_addr = PA'(pc_q); p_wdata = in_word_i;
    s_we = 1'b0; s_addr = SA'(dep_q); s_wdata = top_q;
    h_we = 1'b0; h_addr = HA'(ha_q + 32'(cnt_q)); h_wdata = 8'(top_q >> (8 * cnt_q));
    res = '0;
    d32 = {{(33-SW){1'b0}}, dep_q};

    if (cfg_valid_i) begin
      limit_d = cfg_step_limit_i;
    end
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (st_q)
      smb_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          ost_d = smb_pkg::ST_OK; ofc_d = smb_pkg::F_NONE; opc_d = '0;
          st_d = smb_pkg::S_DONE;
          unique case (in_kind_i)
            smb_pkg::KIND_LOAD: begin
              if (len_q >= PCW'(PROGRAM_DEPTH)) begin
                ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_FULL;
              end else begin
                p_we = 1'b1; p_addr = PA'(len_q); len_d = len_q + 1'b1;
              end
            end
            smb_pkg::KIND_CLEAR: begin
              len_d = '0; dep_d = '0; hl_d = '0; top_d = '0; swp_d = '0;
              st_d = smb_pkg::S_CLR;
            end
            smb_pkg::KIND_RUN: begin
              rem_d = limit_q; pc_d = '0; st_d = smb_pkg::S_FETCH;
            end
            default: ;
          endcase
        end
      end
      // zero the heap one byte a cycle; the sweep after reset posts no result
      smb_pkg::S_CLR: begin
        h_we = 1'b1; h_addr = swp_q; h_wdata = '0; swp_d = swp_q + 1'b1;
        if (swp_q == HA'(HEAP_BYTES - 1)) begin
          st_d = init_q ? smb_pkg::S_IDLE : smb_pkg::S_DONE;
          init_d = 1'b0;
        end
      end
      smb_pkg::S_DONE: begin
        out_vld_d = 1'b1; st_d = smb_pkg::S_IDLE;
      end
      smb_pkg::S_FETCH: begin
        at_d = pc_q;
        if (rem_q == '0) begin
          ost_d = smb_pkg::ST_LIMIT; opc_d = pc_q; st_d = smb_pkg::S_DONE;
        end else if (pc_q >= len_q) begin
          rem_d = rem_q - 1'b1;
          ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_FETCH; opc_d = pc_q;
          st_d = smb_pkg::S_DONE;
        end else begin
          rem_d = rem_q - 1'b1; pc_d = pc_q + 1'b1; st_d = smb_pkg::S_OP;
        end
      end
      smb_pkg::S_OP: begin
        op_d = p_rdata;
        ost_d = smb_pkg::ST_FAULT; opc_d = at_q;
        st_d = smb_pkg::S_DONE;
        unique if (p_rdata == smb_pkg::OP_HALT) begin
          ost_d = smb_pkg::ST_HALT;
        end else if (p_rdata == smb_pkg::OP_PUSH || p_rdata == smb_pkg::OP_COPY ||
                     p_rdata == smb_pkg::OP_DROP || p_rdata == smb_pkg::OP_NEW) begin
          if (pc_q >= len_q) begin
            ofc_d = smb_pkg::F_FETCH; opc_d = pc_q;
          end else begin
            pc_d = pc_q + 1'b1; st_d = smb_pkg::S_ARG;
          end
        end else if (p_rdata == smb_pkg::OP_STORE || p_rdata == smb_pkg::OP_RD32) begin
          if (dep_q < SW'(1)) begin
            ofc_d = smb_pkg::F_UNDERFLOW;
          end else if (pc_q >= len_q) begin
            ofc_d = smb_pkg::F_FETCH; opc_d = pc_q;
          end else begin
            pc_d = pc_q + 1'b1; st_d = smb_pkg::S_ARG;
          end
        end else if (p_rdata == smb_pkg::OP_SV32) begin
          if (dep_q < SW'(2)) begin
            ofc_d = smb_pkg::F_UNDERFLOW;
          end else if (pc_q >= len_q) begin
            ofc_d = smb_pkg::F_FETCH; opc_d = pc_q;
          end else begin
            pc_d = pc_q + 1'b1; st_d = smb_pkg::S_ARG;
          end
        end else if (p_rdata == smb_pkg::OP_JUMP) begin
          if (dep_q < SW'(1)) begin
            ofc_d = smb_pkg::F_UNDERFLOW;
          end else begin
            pc_d = sat_pc(top_q); dep_d = dep_q - 1'b1;
            ost_d = ost_q; st_d = smb_pkg::S_TOPRD;
          end
        end else if (p_rdata == smb_pkg::OP_SWAP || p_rdata == smb_pkg::OP_JIFZ ||
                     p_rdata == smb_pkg::OP_GT || p_rdata == smb_pkg::OP_ADD ||
                     p_rdata == smb_pkg::OP_SUB) begin
          if (dep_q < SW'(2)) begin
            ofc_d = smb_pkg::F_UNDERFLOW;
          end else begin
            s_addr = SA'(dep_q - SW'(2)); ost_d = ost_q; st_d = smb_pkg::S_STK;
          end
        end else begin
          ofc_d = smb_pkg::F_OPCODE;
        end
        if (st_d != smb_pkg::S_DONE) begin
          ofc_d = ofc_q; opc_d = opc_q;
        end
      end
      smb_pkg::S_ARG: begin
        arg_d = p_rdata;
        st_d = smb_pkg::S_FETCH;
        unique case (1'b1)
          (op_q == smb_pkg::OP_PUSH): begin
            if (dep_q >= SW'(STACK_DEPTH)) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_OVERFLOW; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else begin
              s_we = 1'b1; s_wdata = p_rdata; top_d = p_rdata; dep_d = dep_q + 1'b1;
            end
          end
          (op_q == smb_pkg::OP_COPY): begin
            if ({1'b0, p_rdata} >= d32) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_INDEX; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else if (dep_q >= SW'(STACK_DEPTH)) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_OVERFLOW; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else begin
              s_addr = SA'(32'(dep_q) - 32'd1 - p_rdata); st_d = smb_pkg::S_STK;
            end
          end
          (op_q == smb_pkg::OP_STORE): begin
            if ({1'b0, p_rdata} >= d32 - 33'd1) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_INDEX; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else begin
              s_we = 1'b1; s_addr = SA'(32'(dep_q) - 32'd2 - p_rdata);
              dep_d = dep_q - 1'b1; st_d = smb_pkg::S_TOPRD;
            end
          end
          (op_q == smb_pkg::OP_DROP): begin
            if ({1'b0, p_rdata} > d32) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_UNDERFLOW; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else begin
              dep_d = dep_q - SW'(p_rdata); st_d = smb_pkg::S_TOPRD;
            end
          end
          (op_q == smb_pkg::OP_NEW): begin
            if (p_rdata == '0 ||
                {{(33-HW){1'b0}}, hl_q} + {1'b0, p_rdata} > 33'(HEAP_BYTES)) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_ALLOC; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else if (dep_q >= SW'(STACK_DEPTH)) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_OVERFLOW; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else begin
              s_we = 1'b1; s_wdata = 32'(hl_q); top_d = 32'(hl_q);
              dep_d = dep_q + 1'b1; hl_d = hl_q + HW'(p_rdata);
            end
          end
          (op_q == smb_pkg::OP_SV32): begin
            s_addr = SA'(dep_q - SW'(2)); st_d = smb_pkg::S_STK;
          end
          default: begin
            // rd32: address from the top entry
            ha_d = top_q + p_rdata; cnt_d = '0;
            if ({1'b0, top_q + p_rdata} + 33'd4 > {{(33-HW){1'b0}}, hl_q}) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_HEAP; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else begin
              st_d = smb_pkg::S_HRD;
            end
          end
        endcase
      end
      // stack read data is valid here
      smb_pkg::S_STK: begin
        rd_d = s_rdata;
        st_d = smb_pkg::S_FETCH;
        unique case (1'b1)
          (op_q == smb_pkg::OP_COPY): begin
            s_we = 1'b1; s_wdata = s_rdata; top_d = s_rdata; dep_d = dep_q + 1'b1;
          end
          (op_q == smb_pkg::OP_SWAP): begin
            s_we = 1'b1; s_addr = SA'(dep_q - SW'(2)); st_d = smb_pkg::S_SWP;
          end
          (op_q == smb_pkg::OP_JIFZ): begin
            if (top_q == '0) begin
              pc_d = sat_pc(s_rdata);
            end
            dep_d = dep_q - SW'(2); st_d = smb_pkg::S_TOPRD;
          end
          (op_q == smb_pkg::OP_SV32): begin
            ha_d = s_rdata + arg_q; cnt_d = '0;
            if ({1'b0, s_rdata + arg_q} + 33'd4 > {{(33-HW){1'b0}}, hl_q}) begin
              ost_d = smb_pkg::ST_FAULT; ofc_d = smb_pkg::F_HEAP; opc_d = at_q;
              st_d = smb_pkg::S_DONE;
            end else begin
              st_d = smb_pkg::S_HWR;
            end
          end
          default: begin
            if (op_q == smb_pkg::OP_GT) begin
              res = ($signed(s_rdata) > $signed(top_q)) ? 32'd1 : 32'd0;
            end else if (op_q == smb_pkg::OP_ADD) begin
              res = s_rdata + top_q;
            end else begin
              res = s_rdata - top_q;
            end
            s_we = 1'b1; s_addr = SA'(dep_q - SW'(2)); s_wdata = res;
            top_d = res; dep_d = dep_q - 1'b1;
          end
        endcase
      end
      smb_pkg::S_SWP: begin
        s_we = 1'b1; s_addr = SA'(dep_q - 1'b1); s_wdata = rd_q; top_d = rd_q;
        st_d = smb_pkg::S_FETCH;
      end
      // reload the cached top after the depth moved down
      smb_pkg::S_TOPRD: begin
        s_addr = SA'(dep_q - 1'b1);
        if (dep_q == '0) begin
          top_d = '0; st_d = smb_pkg::S_FETCH;
        end else begin
          st_d = smb_pkg::S_TOPLD;
        end
      end
      smb_pkg::S_TOPLD: begin
        top_d = s_rdata; st_d = smb_pkg::S_FETCH;
      end
      // little-endian store, one byte a cycle
      smb_pkg::S_HWR: begin
        h_we = 1'b1; cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd3) begin
          dep_d = dep_q - SW'(2); st_d = smb_pkg::S_TOPRD;
        end
      end
      // byte reads overlap with the capture of the previous byte
      smb_pkg::S_HRD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          rd_d = {h_rdata, rd_q[31:8]};
        end
        if (cnt_q == 3'd4) begin
          s_we = 1'b1; s_addr = SA'(dep_q - 1'b1); s_wdata = {h_rdata, rd_q[31:8]};
          top_d = {h_rdata, rd_q[31:8]}; st_d = smb_pkg::S_FETCH;
        end
      end
      default: st_d = smb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= smb_pkg::S_CLR; limit_q <= smb_pkg::STEP_LIMIT_RST; len_q <= '0;
      dep_q <= '0; hl_q <= '0; top_q <= '0; swp_q <= '0; out_vld_q <= 1'b0;
      rem_q <= '0; pc_q <= '0; cnt_q <= '0; init_q <= 1'b1;
    end else begin
      st_q <= st_d; limit_q <= limit_d; len_q <= len_d; dep_q <= dep_d; hl_q <= hl_d;
      top_q <= top_d; swp_q <= swp_d; out_vld_q <= out_vld_d; rem_q <= rem_d;
      pc_q <= pc_d; cnt_q <= cnt_d; init_q <= init_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    at_q <= at_d; op_q <= op_d; arg_q <= arg_d; rd_q <= rd_d; ha_q <= ha_d;
    ost_q <= ost_d; ofc_q <= ofc_d; opc_q <= opc_d;
  end

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q <= SW'(STACK_DEPTH)) else $error("stack depth beyond capacity");
  a_heap_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hl_q <= HW'(HEAP_BYTES)) else $error("heap use beyond capacity");
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= PCW'(PROGRAM_DEPTH)) else $error("program length beyond capacity");
  a_empty_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && dep_q == '0) |-> top_q == '0) else $error("empty stack shows a top");

endmodule
